// ----- design/lct_pkg.sv -----
package lct_pkg;

    // default sizes
    localparam int LCT_MAX_TAPS    = 32;
    localparam int LCT_SAMPLE_BITS = 16;
    localparam int LCT_RES_W       = 40;
    localparam int LCT_TRIM_W      = 2;

    // output selection codes
    typedef enum logic [LCT_TRIM_W-1:0] {
        TRIM_FULL  = 2'd0,
        TRIM_SAME  = 2'd1,
        TRIM_VALID = 2'd2
    } t_trim;

    // item kinds
    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // control broadcast to every cell of the tap chain
    typedef struct packed {
        logic advance;
        logic clear;
    } t_chain_ctrl;

endpackage

// ----- design/lct_ifs.sv -----
// input items: kernel taps and signal samples
interface lct_in_if import lct_pkg::*; #(
    parameter int SAMPLE_BITS = LCT_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last;

    modport source (output valid, output mode, output value, output last, input ready);
    modport sink   (input valid, input mode, input value, input last, output ready);
endinterface

// result items
interface lct_out_if import lct_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [LCT_RES_W-1:0] result_value;
    logic                        result_last;

    modport source (output valid, output result_value, output result_last, input ready);
    modport sink   (input valid, input result_value, input result_last, output ready);
endinterface

// configuration write channel
interface lct_cfg_if import lct_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [LCT_TRIM_W-1:0] trim_mode;

    modport source (output valid, output trim_mode, input ready);
    modport sink   (input valid, input trim_mode, output ready);
endinterface

// ----- design/lct_cell.sv -----
module lct_cell import lct_pkg::*; #(
    parameter int SAMPLE_BITS = LCT_SAMPLE_BITS,
    parameter int ACC_W       = 2 * LCT_SAMPLE_BITS + 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_chain_ctrl                   i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_coef_we,
    input  logic                          i_tap_on,
    input  logic signed [ACC_W-1:0]       i_acc,
    output logic signed [ACC_W-1:0]       o_acc
);

    logic signed [SAMPLE_BITS-1:0]   r_coef;
    logic signed [SAMPLE_BITS-1:0]   coef_eff;
    logic signed [2*SAMPLE_BITS-1:0] prod;
    logic signed [ACC_W-1:0]         r_acc;
    logic signed [ACC_W-1:0]         n_acc;

    // taps at or beyond the loaded count take no part
    assign coef_eff = i_tap_on ? r_coef : '0;
    assign prod     = coef_eff * i_sample;
    assign n_acc    = i_acc + ACC_W'(prod);
    assign o_acc    = r_acc;

    // coefficient of this tap
    always_ff @(posedge i_clk) begin
        if (i_coef_we) begin
            r_coef <= i_sample;
        end
    end

    // partial sum handed on towards the chain head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.advance) begin
            r_acc <= n_acc;
        end
    end

endmodule

// ----- design/lct_hold_buf.sv -----
module lct_hold_buf import lct_pkg::*; #(
    parameter int DEPTH = LCT_MAX_TAPS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic signed [LCT_RES_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic signed [LCT_RES_W-1:0] o_rdata
);

    logic signed [LCT_RES_W-1:0] r_mem [DEPTH];
    logic signed [LCT_RES_W-1:0] r_rdata;

    assign o_rdata = r_rdata;

    // early outputs of the signal, kept while the cut is still open
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/linear_convolution_trim_unit.sv -----
// Linear convolution of a sample stream with a loaded kernel, cut to full,
// same or valid length.
// i_in_s carries items: mode 0 loads a kernel tap (last closes the kernel,
// the next tap starts a new one), mode 1 is a signal sample (last ends the
// signal). Any tap abandons the signal in progress. o_res carries results,
// result_last marks the final output of the selected cut. i_cfg writes
// trim_mode (0 full, 1 same, 2 valid, 3 ignored); write it only while idle.
// A tap item is taken in the idle state and so is a sample that yields
// nothing; otherwise the sequencer replays P held early outputs from the
// hold buffer (a read state, then an output state each), emits the current
// result, then F flush steps of zeros through the tap chain, each followed
// by a result, plus a done state at the signal end. The next item is taken
// only back in idle; every result is registered in the output register.
// The output register keeps a result while the receiver stalls; the next
// item is still accepted once the sequencer is idle, and the sequencer
// waits while the output register stays full.
// Reset empties the tap chain and counters and selects full; there is no
// clearing pass, so the block is ready in the first cycle after reset.
module linear_convolution_trim_unit import lct_pkg::*; #(
    parameter int MAX_TAPS    = LCT_MAX_TAPS,
    parameter int SAMPLE_BITS = LCT_SAMPLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lct_in_if.sink      i_in_s,
    lct_out_if.source   o_res,
    lct_cfg_if.sink     i_cfg
);

    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int IW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int ACC_W = 2 * SAMPLE_BITS + $clog2(MAX_TAPS);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_PAST = 6'b000100,
        ST_CUR  = 6'b001000,
        ST_FADV = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state                        r_state, n_state;
    t_trim                         r_trim;
    logic [CW-1:0]                 r_taps;
    logic                          r_closed;
    logic [CW-1:0]                 r_seen;

    // per-sample plan
    logic                          r_end;
    logic [IW-1:0]                 r_ptr;
    logic [CW-1:0]                 r_past_cnt;
    logic [CW-1:0]                 r_flush_cnt;
    logic                          n_emit;
    logic [CW-1:0]                 n_jlo, n_npast, n_nflush;

    logic                          r_bw;
    logic [IW-1:0]                 r_bw_addr;

    logic                          r_res_valid;
    logic signed [LCT_RES_W-1:0]   r_res_value;
    logic                          r_res_last;

    logic                          acc_in, is_sample, is_tap;
    logic                          out_free, load_res;
    logic signed [LCT_RES_W-1:0]   res_value;
    logic                          res_last;
    logic [CW-1:0]                 seen_next, m_m1, newest, half_s, start;
    logic                          long_sig, first;
    logic [CW-1:0]                 tap_idx;
    logic                          tap_we;
    t_chain_ctrl                   chain_ctrl;
    logic signed [SAMPLE_BITS-1:0] chain_u;
    logic [MAX_TAPS-1:0]           coef_we, tap_on;
    logic signed [ACC_W-1:0]       acc_link [MAX_TAPS+1];
    logic signed [LCT_RES_W-1:0]   sat_acc;
    logic signed [LCT_RES_W-1:0]   buf_rdata;

    // handshakes
    assign i_in_s.ready = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign acc_in       = i_in_s.valid && (r_state == ST_IDLE);
    assign is_sample    = (i_in_s.mode == KIND_SAMPLE);
    assign is_tap       = (i_in_s.mode == KIND_TAP);

    assign o_res.valid        = r_res_valid;
    assign o_res.result_value = r_res_value;
    assign o_res.result_last  = r_res_last;
    assign out_free           = !r_res_valid || o_res.ready;

    // signal position and cut bounds
    assign seen_next = (r_seen < CW'(MAX_TAPS)) ? r_seen + CW'(1) : r_seen;
    assign m_m1      = r_taps - CW'(1);
    assign long_sig  = (seen_next >= r_taps);
    assign first     = long_sig && (r_seen == m_m1);
    assign newest    = seen_next - CW'(1);
    assign half_s    = m_m1 >> 1;
    assign start     = newest >> 1;

    // which results a sample releases: held ones, the current one, flushes
    always_comb begin
        n_emit   = 1'b0;
        n_jlo    = '0;
        n_npast  = '0;
        n_nflush = '0;
        if (r_taps != '0) begin
            unique case (r_trim)
                TRIM_SAME: begin
                    if (long_sig) begin
                        n_emit = 1'b1;
                        if (first) begin
                            n_jlo   = half_s;
                            n_npast = m_m1 - half_s;
                        end
                        if (i_in_s.last) begin
                            n_nflush = half_s;
                        end
                    end else if (i_in_s.last) begin
                        n_emit   = 1'b1;
                        n_jlo    = start;
                        n_npast  = newest - start;
                        n_nflush = m_m1 - (newest - start);
                    end
                end
                TRIM_VALID: begin
                    if (long_sig) begin
                        n_emit = 1'b1;
                    end else if (i_in_s.last) begin
                        n_emit   = 1'b1;
                        n_nflush = m_m1 - newest;
                    end
                end
                default: begin
                    n_emit = 1'b1;
                    if (i_in_s.last) begin
                        n_nflush = m_m1;
                    end
                end
            endcase
        end
    end

    // kernel load addressing
    assign tap_idx = r_closed ? '0 : r_taps;
    assign tap_we  = acc_in && is_tap && (tap_idx < CW'(MAX_TAPS));

    // tap chain control
    assign chain_ctrl.advance = (acc_in && is_sample) || (r_state == ST_FADV);
    assign chain_ctrl.clear   = (acc_in && is_tap) || (r_state == ST_DONE);
    assign chain_u            = (r_state == ST_FADV) ? '0 : i_in_s.value;
    assign acc_link[MAX_TAPS] = '0;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        assign coef_we[k] = tap_we && (tap_idx == CW'(k));
        assign tap_on[k]  = (r_taps > CW'(k));

        lct_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .ACC_W       (ACC_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (chain_ctrl),
            .i_sample  (chain_u),
            .i_coef_we (coef_we[k]),
            .i_tap_on  (tap_on[k]),
            .i_acc     (acc_link[k+1]),
            .o_acc     (acc_link[k])
        );
    end

    // chain head limited to the result width
    if (ACC_W > LCT_RES_W) begin : g_sat
        logic fits;
        assign fits = (&acc_link[0][ACC_W-1:LCT_RES_W-1])
                   || (~|acc_link[0][ACC_W-1:LCT_RES_W-1]);
        assign sat_acc = fits ? acc_link[0][LCT_RES_W-1:0]
                       : (acc_link[0][ACC_W-1] ? {1'b1, {(LCT_RES_W-1){1'b0}}}
                                               : {1'b0, {(LCT_RES_W-1){1'b1}}});
    end else begin : g_ext
        assign sat_acc = LCT_RES_W'(acc_link[0]);
    end

    lct_hold_buf #(
        .DEPTH (MAX_TAPS),
        .AW    (IW)
    ) u_hold_buf (
        .i_clk   (i_clk),
        .i_we    (r_bw),
        .i_waddr (r_bw_addr),
        .i_wdata (sat_acc),
        .i_raddr (r_ptr),
        .o_rdata (buf_rdata)
    );

    // result selection
    assign load_res  = ((r_state == ST_PAST) || (r_state == ST_CUR)) && out_free;
    assign res_value = (r_state == ST_PAST) ? buf_rdata : sat_acc;
    assign res_last  = (r_state == ST_CUR) && r_end && (r_flush_cnt == '0);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_in && is_sample) begin
                    if (n_emit) begin
                        n_state = (n_npast != '0) ? ST_RD : ST_CUR;
                    end else if (i_in_s.last) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_PAST;
            end
            ST_PAST: begin
                if (out_free) begin
                    n_state = (r_past_cnt == CW'(1)) ? ST_CUR : ST_RD;
                end
            end
            ST_CUR: begin
                if (out_free) begin
                    if (r_flush_cnt != '0) begin
                        n_state = ST_FADV;
                    end else if (r_end) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FADV: begin
                n_state = ST_CUR;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_trim      <= TRIM_FULL;
            r_taps      <= '0;
            r_closed    <= 1'b1;
            r_seen      <= '0;
            r_end       <= 1'b0;
            r_past_cnt  <= '0;
            r_flush_cnt <= '0;
            r_bw        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bw    <= acc_in && is_sample && (r_seen < CW'(MAX_TAPS));

            // a write of the unused code leaves the selection alone
            if (i_cfg.valid && (i_cfg.trim_mode <= LCT_TRIM_W'(TRIM_VALID))) begin
                r_trim <= t_trim'(i_cfg.trim_mode);
            end

            // kernel load, which also drops the signal in progress
            if (acc_in && is_tap) begin
                r_taps   <= tap_we ? tap_idx + CW'(1) : tap_idx;
                r_closed <= i_in_s.last;
                r_seen   <= '0;
            end

            // sample accepted: count it and latch its plan
            if (acc_in && is_sample) begin
                r_seen      <= seen_next;
                r_end       <= i_in_s.last;
                r_past_cnt  <= n_npast;
                r_flush_cnt <= n_nflush;
            end

            if ((r_state == ST_PAST) && out_free) begin
                r_past_cnt <= r_past_cnt - CW'(1);
            end
            if (r_state == ST_FADV) begin
                r_flush_cnt <= r_flush_cnt - CW'(1);
            end

            // signal end
            if (r_state == ST_DONE) begin
                r_seen <= '0;
            end

            if (load_res) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc_in && is_sample) begin
            r_ptr     <= n_jlo[IW-1:0];
            r_bw_addr <= r_seen[IW-1:0];
        end else if ((r_state == ST_PAST) && out_free) begin
            r_ptr <= r_ptr + IW'(1);
        end
        if (load_res) begin
            r_res_value <= res_value;
            r_res_last  <= res_last;
        end
    end

endmodule

// ----- verif/tb_linear_convolution_trim_unit.sv -----
module tb_linear_convolution_trim_unit import lct_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 8;
    localparam int MAX_GAP       = 5;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RAND_ITEMS    = 200;
    localparam int HIST_DEPTH    = LCT_MAX_TAPS;
    localparam int POS_MAX       = 127;
    localparam int DIR_ROWS      = 22;

    // write code outside the legal range, must be ignored
    localparam logic [LCT_TRIM_W-1:0] TRIM_BAD = 2'd3;

    localparam longint RES_MAX = (longint'(1) <<< (LCT_RES_W - 1)) - 1;
    localparam longint RES_MIN = -(longint'(1) <<< (LCT_RES_W - 1));

    typedef enum logic {
        ROW_ITEM,
        ROW_TRIM
    } t_row_kind;

    typedef struct {
        t_row_kind                         kind;
        logic                              mode;
        logic signed [LCT_SAMPLE_BITS-1:0] value;
        logic                              last;
        logic [LCT_TRIM_W-1:0]             trim;
        bit                                typed;
        int                                n_typed;
        logic signed [LCT_RES_W-1:0]       typed_value;
        logic                              typed_last;
    } t_stim_row;

    typedef struct {
        logic signed [LCT_RES_W-1:0] value;
        logic                        last;
    } t_conv_out;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lct_in_if #(.SAMPLE_BITS(LCT_SAMPLE_BITS)) in_if ();
    lct_out_if res_if ();
    lct_cfg_if cfg_if ();

    linear_convolution_trim_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_s  (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    // predictor state: register, kernel and signal history
    t_trim                             trim_sel = TRIM_FULL;
    logic signed [LCT_SAMPLE_BITS-1:0] kern_taps [LCT_MAX_TAPS] = '{default: '0};
    int                                kern_len = 0;
    bit                                kern_closed = 1'b1;
    logic signed [LCT_SAMPLE_BITS-1:0] sig_hist [HIST_DEPTH] = '{default: '0};
    int                                sig_count = 0;
    int                                sig_pos = 0;

    t_conv_out conv_expect_q [$];
    int        fail_count = 0;
    int        items_sent = 0;
    int        quiet_cycles = 0;
    bit        idle_on = 1'b1;
    bit        hold_req = 1'b0;

    // directed items; typed-in results only where they are obvious
    t_stim_row dir_rows [DIR_ROWS] = '{
        // sample with no kernel after reset gives nothing
        '{ROW_ITEM, KIND_SAMPLE, 16'sd1000, 1'b1, TRIM_FULL, 1'b1, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_TAP, 16'sh7FFF, 1'b1, TRIM_FULL, 1'b1, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_SAMPLE, 16'sh7FFF, 1'b1, TRIM_FULL, 1'b1, 1, 40'sd1073676289, 1'b1},
        // new kernel replaces the old one
        '{ROW_ITEM, KIND_TAP, 16'sh8000, 1'b1, TRIM_FULL, 1'b1, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_SAMPLE, 16'sh8000, 1'b1, TRIM_FULL, 1'b1, 1, 40'sd1073741824, 1'b1},
        '{ROW_ITEM, KIND_SAMPLE, 16'sh7FFF, 1'b1, TRIM_FULL, 1'b1, 1, -40'sd1073709056, 1'b1},
        // open kernel, then a tap abandons the signal
        '{ROW_ITEM, KIND_TAP, 16'sd3, 1'b0, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_SAMPLE, 16'sd5, 1'b0, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_TAP, 16'sd2, 1'b1, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        // same cut
        '{ROW_TRIM, KIND_TAP, 16'sd0, 1'b0, TRIM_SAME, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_SAMPLE, 16'sd1, 1'b0, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_SAMPLE, 16'sd2, 1'b0, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_SAMPLE, 16'sd3, 1'b1, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        // cut changed in the middle of a short signal
        '{ROW_TRIM, KIND_TAP, 16'sd0, 1'b0, TRIM_VALID, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_SAMPLE, 16'sd7, 1'b0, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_TRIM, KIND_TAP, 16'sd0, 1'b0, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_SAMPLE, -16'sd7, 1'b1, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        // illegal cut code leaves full selected
        '{ROW_TRIM, KIND_TAP, 16'sd0, 1'b0, TRIM_BAD, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_TAP, 16'sd1, 1'b0, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_TAP, 16'sd1, 1'b1, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_SAMPLE, 16'sd100, 1'b0, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0},
        '{ROW_ITEM, KIND_SAMPLE, 16'sd200, 1'b1, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0}
    };

    function automatic t_stim_row make_item(logic mode, logic signed [15:0] value,
                                            logic last);
        t_stim_row row;
        row = '{ROW_ITEM, mode, value, last, TRIM_FULL, 1'b0, 0, 40'sd0, 1'b0};
        return row;
    endfunction

    // random q15 value, extremes now and then
    function automatic logic signed [LCT_SAMPLE_BITS-1:0] rand_q15();
        case ($urandom_range(0, 7))
            0: begin
                return 16'sh7FFF;
            end
            1: begin
                return 16'sh8000;
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    function automatic void sig_clear();
        for (int i = 0; i < HIST_DEPTH; i++) begin
            sig_hist[i] = '0;
        end
        sig_count = 0;
        sig_pos = 0;
    endfunction

    // convolution outputs at offsets lo..hi from the newest sample
    function automatic void push_outputs(int lo, int hi, bit mark, bit quiet);
        longint    acc;
        int        d;
        t_conv_out entry;
        for (int r = lo; r <= hi; r++) begin
            acc = 0;
            for (int k = 0; k < kern_len; k++) begin
                d = k - r;
                if (d >= 0 && d < HIST_DEPTH) begin
                    acc += longint'(kern_taps[k]) * longint'(sig_hist[d]);
                end
            end
            if (acc > RES_MAX) begin
                acc = RES_MAX;
            end
            if (acc < RES_MIN) begin
                acc = RES_MIN;
            end
            entry.value = acc[LCT_RES_W-1:0];
            entry.last = mark && (r == hi);
            if (!quiet) begin
                conv_expect_q.push_back(entry);
            end
        end
    endfunction

    // update kernel or history for one item and queue its outputs
    function automatic void conv_predict(logic mode, logic signed [15:0] v, logic last,
                                         bit quiet);
        int m;
        int newest;
        int s;
        int prev;
        bit long_sig;
        bit first;
        if (mode == KIND_TAP) begin
            if (kern_closed) begin
                kern_len = 0;
                kern_closed = 1'b0;
            end
            if (kern_len < LCT_MAX_TAPS) begin
                kern_taps[kern_len] = v;
                kern_len++;
            end
            if (last) begin
                kern_closed = 1'b1;
            end
            sig_clear();
            return;
        end
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            sig_hist[i] = sig_hist[i-1];
        end
        sig_hist[0] = v;
        prev = sig_count;
        if (sig_count < LCT_MAX_TAPS) begin
            sig_count++;
        end
        if (sig_pos < POS_MAX) begin
            sig_pos++;
        end
        m = kern_len;
        if (m > 0) begin
            newest = sig_pos - 1;
            long_sig = sig_count >= m;
            first = long_sig && (prev == m - 1);
            case (trim_sel)
                TRIM_SAME: begin
                    s = (m - 1) / 2;
                    if (long_sig) begin
                        push_outputs(first ? s - (m - 1) : 0, last ? s : 0, last, quiet);
                    end else if (last) begin
                        push_outputs(newest / 2 - newest, newest / 2 + m - 1 - newest,
                                     1'b1, quiet);
                    end
                end
                TRIM_VALID: begin
                    if (long_sig) begin
                        push_outputs(0, 0, last, quiet);
                    end else if (last) begin
                        push_outputs(0, m - 1 - newest, 1'b1, quiet);
                    end
                end
                default: begin
                    push_outputs(0, last ? m - 1 : 0, last, quiet);
                end
            endcase
        end
        if (last) begin
            sig_clear();
        end
    endfunction

    // offer one item, predict at acceptance
    task automatic send_item(input t_stim_row row);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.mode = row.mode;
        in_if.value = row.value;
        in_if.last = row.last;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        conv_predict(row.mode, row.value, row.last, row.typed);
        for (int i = 0; i < row.n_typed; i++) begin
            conv_expect_q.push_back('{row.typed_value, row.typed_last});
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    // stop offering until every queued result has come back
    task automatic drain_outputs();
        in_if.valid = 1'b0;
        while (conv_expect_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // cut selection is only changed with the block idle
    task automatic write_trim(input logic [LCT_TRIM_W-1:0] code);
        drain_outputs();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_if.trim_mode = code;
        cfg_if.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (code != TRIM_BAD) begin
            trim_sel = t_trim'(code);
        end
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // result receiver with random stalls and one long hold-off
    initial begin
        int stall;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0) begin
                res_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready = 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            @(negedge i_clk);
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_conv_out want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (conv_expect_q.size() == 0) begin
                $error("result_value: none expected, got %0d", res_if.result_value);
                fail_count++;
            end else begin
                want = conv_expect_q.pop_front();
                if (res_if.result_value !== want.value) begin
                    $error("result_value: expected %0d, got %0d", want.value,
                           res_if.result_value);
                    fail_count++;
                end
                if (res_if.result_last !== want.last) begin
                    $error("result_last: expected %0d, got %0d", want.last,
                           res_if.result_last);
                    fail_count++;
                end
            end
        end
    end

    // cycles without any accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("tb_linear_convolution_trim_unit NOT OK");
        $finish;
    end

    // reset, directed table, then random phases
    initial begin
        int                    phase;
        int                    rand_start;
        int                    n_seq;
        int                    pick;
        int                    sel;
        int                    n_taps;
        int                    n_samp;
        logic [LCT_TRIM_W-1:0] code;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.mode = KIND_TAP;
        in_if.value = '0;
        in_if.last = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.trim_mode = TRIM_FULL;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_TRIM) begin
                write_trim(dir_rows[i].trim);
            end else begin
                send_item(dir_rows[i]);
            end
        end

        phase = 0;
        rand_start = items_sent;
        while (items_sent - rand_start < RAND_ITEMS) begin
            case (phase)
                0: begin
                    code = TRIM_FULL;
                end
                1: begin
                    code = TRIM_SAME;
                end
                2: begin
                    code = TRIM_VALID;
                end
                3: begin
                    code = TRIM_BAD;
                end
                default: begin
                    code = LCT_TRIM_W'($urandom_range(0, 3));
                end
            endcase
            write_trim(code);
            idle_on = (phase % 3 != 2);
            // receiver holds off while the first phase keeps streaming
            if (phase == 0) begin
                hold_req = 1'b1;
            end
            n_seq = $urandom_range(3, 5);
            repeat (n_seq) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    // stray item of any kind
                    send_item(make_item(1'($urandom_range(0, 1)), rand_q15(),
                                        1'($urandom_range(0, 1))));
                end else begin
                    // kernel: mostly short, sometimes full or overlong
                    if (pick == 1 || $urandom_range(0, 2) != 0) begin
                        sel = $urandom_range(0, 19);
                        n_taps = (sel == 0) ? LCT_MAX_TAPS :
                                 (sel == 1) ? $urandom_range(LCT_MAX_TAPS + 1,
                                                             LCT_MAX_TAPS + 2) :
                                 $urandom_range(1, 8);
                        for (int i = 0; i < n_taps; i++) begin
                            send_item(make_item(KIND_TAP, rand_q15(),
                                                pick != 2 && i == n_taps - 1));
                        end
                    end
                    sel = $urandom_range(0, 14);
                    n_samp = (sel == 0) ? 40 : $urandom_range(1, 12);
                    for (int i = 0; i < n_samp; i++) begin
                        send_item(make_item(KIND_SAMPLE, rand_q15(),
                                            pick != 1 && i == n_samp - 1));
                    end
                    // unfinished signal cut off by a tap
                    if (pick == 1) begin
                        send_item(make_item(KIND_TAP, rand_q15(), 1'b1));
                    end
                end
                if ($urandom_range(0, 7) == 0) begin
                    drain_outputs();
                end
            end
            phase++;
        end

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_linear_convolution_trim_unit OK");
        end else begin
            $display("tb_linear_convolution_trim_unit NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/lct_pkg.sv
design/lct_ifs.sv
design/lct_cell.sv
design/lct_hold_buf.sv
design/linear_convolution_trim_unit.sv
verif/tb_linear_convolution_trim_unit.sv
